### sv/mtt_pkg.sv
// ============================================================================
// mtt_pkg: shared types and constants of the timer table
// Action and result codes, register indexes and the front-to-back queue entry.
// ============================================================================
package mtt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_FIRED     = 3'd4
    } kind_t;

    localparam logic REG_DUE_THRESHOLD = 1'b0;
    localparam logic REG_MIN_REPEAT    = 1'b1;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        action_t     action;
        logic [31:0] value;
        logic        repeats;
        logic [15:0] timer_id;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_FLUSH = 2'd2
    } back_state_t;

endpackage

### sv/mtt_front.sv
// ============================================================================
// mtt_front: item intake and classification
// Takes items, clamps periodic intervals, selects the time operand and
// queues the command for the back end.
// ============================================================================
module mtt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [31:0]       interval,
    input  logic              repeats,
    input  logic [15:0]       timer_id,
    input  logic [31:0]       dt,
    input  logic [15:0]       min_repeat,
    output mtt_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);
    import mtt_pkg::*;

    cmd_t       q_reg [QUEUE_DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       push;
    cmd_t       in_cmd;

    assign busy      = (cnt_reg == 2'(QUEUE_DEPTH));
    assign push      = start && !busy && (action != ACT_NONE);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    // Classify and clamp the item before it enters the queue.
    always_comb
    begin
        in_cmd.action   = action_t'(action);
        in_cmd.repeats  = repeats;
        in_cmd.timer_id = timer_id;
        if (action == ACT_TICK)
            in_cmd.value = dt;
        else if (repeats && interval < {16'd0, min_repeat})
            in_cmd.value = {16'd0, min_repeat};
        else
            in_cmd.value = interval;
    end

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (cmd_pop)
                rd_reg <= ~rd_reg;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= in_cmd;
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");

endmodule

### sv/mtt_back.sv
// ============================================================================
// mtt_back: timer table execution
// Holds the table, carries out add, cancel and tick, and drives results.
// A tick walks the table one entry a cycle and compacts it as it goes.
// ============================================================================
module mtt_back #(
    parameter int SLOTS = mtt_pkg::SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mtt_pkg::cmd_t     cmd,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  logic [15:0]       due_threshold,
    output logic              done,
    output logic [2:0]        kind,
    output logic [15:0]       result_id,
    output logic              last
);
    import mtt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [15:0] id_mem [SLOTS];
    logic [31:0] ivl_mem [SLOTS];
    logic [33:0] rem_mem [SLOTS];
    logic        per_mem [SLOTS];
    logic        dead_mem [SLOTS];

    back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic [15:0]   next_id_reg, next_id_next;
    logic [31:0]   dt_reg, dt_next;
    logic          pend_reg, pend_next;
    logic [15:0]   pend_id_reg, pend_id_next;
    logic          done_reg, done_next;
    logic [2:0]    kind_reg, kind_next;
    logic [15:0]   rid_reg, rid_next;
    logic          last_reg, last_next;

    // Cancel search over the live prefix.
    logic          hit;
    logic [IW-1:0] hit_idx;
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (CW'(i) < count_reg && !dead_mem[i] && id_mem[i] == cmd.timer_id)
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // One entry of the walk.
    logic [IW-1:0] ri, ki;
    logic [33:0]   sub, rel, new_rem;
    logic          alive, fire, keep_it;
    always_comb
    begin
        ri      = rd_reg[IW-1:0];
        ki      = keep_reg[IW-1:0];
        alive   = !dead_mem[ri];
        sub     = rem_mem[ri] - {2'b00, dt_reg};
        fire    = alive && ($signed(sub) <= $signed({18'd0, due_threshold}));
        rel     = sub + {2'b00, ivl_mem[ri]};
        if (!fire)
            new_rem = sub;
        else if (rel[33])
            new_rem = {2'b00, ivl_mem[ri]};
        else
            new_rem = rel;
        keep_it = alive && !(fire && !per_mem[ri]);
    end

    // Sequencer.
    logic          wr_add, wr_cancel, wr_walk;
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        keep_next    = keep_reg;
        next_id_next = next_id_reg;
        dt_next      = dt_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        done_next    = 1'b0;
        kind_next    = kind_reg;
        rid_next     = rid_reg;
        last_next    = 1'b0;
        cmd_pop      = 1'b0;
        wr_add       = 1'b0;
        wr_cancel    = 1'b0;
        wr_walk      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.action)
                        ACT_ADD:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (count_reg == CW'(SLOTS))
                            begin
                                kind_next = KIND_FULL;
                                rid_next  = '0;
                            end
                            else
                            begin
                                wr_add       = 1'b1;
                                kind_next    = KIND_ADDED;
                                rid_next     = next_id_reg;
                                count_next   = count_reg + 1'b1;
                                next_id_next = next_id_reg + 16'd1;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            rid_next  = cmd.timer_id;
                            wr_cancel = hit;
                            kind_next = hit ? KIND_CANCELLED : KIND_NOT_FOUND;
                        end
                        ACT_TICK:
                        begin
                            dt_next    = cmd.value;
                            rd_next    = '0;
                            keep_next  = '0;
                            pend_next  = 1'b0;
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (rd_reg == count_reg)
                begin
                    count_next = keep_reg;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    wr_walk = keep_it;
                    if (keep_it)
                        keep_next = keep_reg + 1'b1;
                    rd_next = rd_reg + 1'b1;
                    if (fire)
                    begin
                        // Hold one fired id back so the final one can carry last.
                        if (pend_reg)
                        begin
                            done_next = 1'b1;
                            kind_next = KIND_FIRED;
                            rid_next  = pend_id_reg;
                        end
                        pend_next    = 1'b1;
                        pend_id_next = id_mem[ri];
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_reg)
                begin
                    done_next = 1'b1;
                    last_next = 1'b1;
                    kind_next = KIND_FIRED;
                    rid_next  = pend_id_reg;
                end
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_reg      <= '0;
            keep_reg    <= '0;
            next_id_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_reg      <= rd_next;
            keep_reg    <= keep_next;
            next_id_reg <= next_id_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg      <= dt_next;
        pend_id_reg <= pend_id_next;
        kind_reg    <= kind_next;
        rid_reg     <= rid_next;
    end

    // Table writes: append, cancel mark, and compacting write-back.
    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            id_mem[count_reg[IW-1:0]]   <= next_id_reg;
            ivl_mem[count_reg[IW-1:0]]  <= cmd.value;
            rem_mem[count_reg[IW-1:0]]  <= {2'b00, cmd.value};
            per_mem[count_reg[IW-1:0]]  <= cmd.repeats;
            dead_mem[count_reg[IW-1:0]] <= 1'b0;
        end
        else if (wr_cancel)
        begin
            dead_mem[hit_idx] <= 1'b1;
        end
        else if (wr_walk)
        begin
            id_mem[ki]   <= id_mem[ri];
            ivl_mem[ki]  <= ivl_mem[ri];
            rem_mem[ki]  <= new_rem;
            per_mem[ki]  <= per_mem[ri];
            dead_mem[ki] <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign kind      = kind_reg;
    assign result_id = rid_reg;
    assign last      = last_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS)) else $error("entry count out of range");
    a_keep_le_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> keep_reg <= rd_reg) else $error("compaction overran");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> done_reg) else $error("last without result");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == ST_IDLE) else $error("pop while busy");

endmodule

### sv/multi_timer_table_core.sv
// ============================================================================
// multi_timer_table_core: table of one-shot and periodic timers
// Top level: configuration registers, intake front end and table back end.
// ============================================================================
// Results come out on done/kind/result_id/last, one per cycle, and cannot be
// stalled. An add or a cancel gives its single result through the command
// queue and then the registered result outputs. A tick is taken from the
// queue in the idle state, walks the table one entry per cycle in the back
// end and ends in a closing state that sends the final fired id; fired
// ids come out during the walk, the last one flagged by last. A two-entry
// command queue lets start be taken while a tick is still walking; busy rises
// only when that queue is full.
module multi_timer_table_core #(
    parameter int SLOTS = mtt_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] interval,
    input  logic        repeats,
    input  logic [15:0] timer_id,
    input  logic [31:0] dt,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [2:0]  kind,
    output logic [15:0] result_id,
    output logic        last
);
    import mtt_pkg::*;

    logic [15:0] due_reg, minrep_reg;
    cmd_t        cmd;
    logic        cmd_valid, cmd_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg    <= 16'd7;
            minrep_reg <= 16'd273;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DUE_THRESHOLD)
                due_reg <= cfg_data;
            else
                minrep_reg <= cfg_data;
        end
    end

    mtt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .interval(interval), .repeats(repeats),
        .timer_id(timer_id), .dt(dt), .min_repeat(minrep_reg),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
    );

    mtt_back #(.SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop), .due_threshold(due_reg), .done(done),
        .kind(kind), .result_id(result_id), .last(last)
    );

endmodule
